// ===== rtl/crl_pkg.sv =====
// Shared types, constants and functions of the client request rate limiter.
package crl_pkg;

   localparam int TABLE_ENTRIES = 4096;
   localparam int IDX_BITS = $clog2(TABLE_ENTRIES);
   localparam int ALLOW_ENTRIES = 16;
   localparam int ALLOW_BITS = (ALLOW_ENTRIES > 1) ? $clog2(ALLOW_ENTRIES) : 1;
   localparam int COUNT_BITS = 16;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS = 1;
   localparam int KEY_BITS = 66;

   localparam logic [1:0] VERDICT_ALLOW = 2'd0;
   localparam logic [1:0] VERDICT_DENY = 2'd1;
   localparam logic [1:0] VERDICT_BYPASS = 2'd2;

   localparam logic [1:0] ETYPE_HOLD = 2'd0;
   localparam logic [1:0] ETYPE_PAGE = 2'd1;
   localparam logic [1:0] ETYPE_SITE = 2'd2;

   localparam logic KIND_CHECK = 1'b0;
   localparam logic KIND_ALLOW_ADD = 1'b1;

   localparam logic [2:0] CSR_PAGE_LIMIT = 3'd0;
   localparam logic [2:0] CSR_PAGE_WINDOW = 3'd1;
   localparam logic [2:0] CSR_SITE_LIMIT = 3'd2;
   localparam logic [2:0] CSR_SITE_WINDOW = 3'd3;
   localparam logic [2:0] CSR_HOLD_TIME = 3'd4;

   typedef struct packed {
      logic        kind;
      logic [31:0] client_addr;
      logic [31:0] page_id;
      logic [31:0] now_seconds;
      logic        excluded;
      logic [2:0]  prefix_octets;
   } req_type;

   typedef struct packed {
      logic [1:0] verdict;
      logic       hold_started;
      logic       table_full;
   } rsp_type;

   typedef struct packed {
      logic                  valid;
      logic [1:0]            etype;
      logic [31:0]           addr;
      logic [31:0]           page;
      logic [31:0]           stamp;
      logic [COUNT_BITS-1:0] count;
   } tbl_entry_type;

   typedef struct packed {
      req_type             req;
      logic [IDX_BITS-1:0] hold_idx;
      logic [IDX_BITS-1:0] page_idx;
      logic [IDX_BITS-1:0] site_idx;
   } work_type;

   typedef struct packed {
      logic [15:0] page_limit;
      logic [15:0] page_window;
      logic [15:0] site_limit;
      logic [15:0] site_window;
      logic [15:0] hold_time;
   } cfg_type;

   typedef enum logic [2:0] {
      BS_CLEAR,
      BS_IDLE,
      BS_CLASSIFY,
      BS_READ,
      BS_COMPARE,
      BS_ACT,
      BS_DONE
   } back_state_type;

   typedef enum logic [1:0] {
      PH_HOLD,
      PH_PAGE,
      PH_SITE,
      PH_STORE
   } phase_type;

   function automatic logic [IDX_BITS-1:0] slot_hash(logic [1:0] etype, logic [31:0] addr,
                                                     logic [31:0] page);
      logic [KEY_BITS-1:0] key;
      logic [IDX_BITS-1:0] h;
      key = {etype, addr, page ^ {addr[15:0], addr[31:16]}};
      h = '0;
      for (int i = 0; i < KEY_BITS; i++) begin
         h[i % IDX_BITS] = h[i % IDX_BITS] ^ key[i];
      end
      return h;
   endfunction

   function automatic logic [31:0] prefix_mask(logic [2:0] octets);
      logic [31:0] m;
      case (octets)
         3'd1: m = 32'hFF00_0000;
         3'd2: m = 32'hFFFF_0000;
         3'd3: m = 32'hFFFF_FF00;
         default: m = 32'hFFFF_FFFF;
      endcase
      return m;
   endfunction

endpackage

// ===== rtl/client_request_rate_limiter_top.sv =====
// Top level of the client request rate limiter: register file, front queue and back part.
//
// Requests arrive on the req_ channel (valid/ready) and one result per request
// leaves on the rsp_ channel (valid/ready). A transfer on req_ is hashed and put
// into a two-entry queue, so further requests are taken while one is worked on.
// The back part handles one request at a time against a 4096-entry table held in
// a single RAM with one read and one write port. Each table lookup is a linear
// probe, with a read step and a compare step per slot visited. A request that is
// not whitelisted or excluded starts with the hold lookup and then, unless a hold
// denies it, goes on to the page and site lookups; whitelist adds and bypassed requests
// do no lookup. Each extra probe adds a read and a compare step, and a denial that stores a hold adds one more lookup.
// After reset the back part clears all 4096 entries of the table, one entry a cycle;
// requests queue up meanwhile. Configuration writes on the csr_ port take effect
// at once and are expected only while the block is idle.
// The result register holds a finished result while the receiver stalls; the back
// part then waits, and the queue keeps taking requests until it is full.
module client_request_rate_limiter_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  crl_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output crl_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [2:0]       csr_index,
   input  logic [15:0]      csr_wdata
);

   crl_pkg::cfg_type  cfg_ff, cfg_in;
   crl_pkg::work_type q_data;
   logic              q_valid, q_pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            crl_pkg::CSR_PAGE_LIMIT:  cfg_in.page_limit = csr_wdata;
            crl_pkg::CSR_PAGE_WINDOW: cfg_in.page_window = csr_wdata;
            crl_pkg::CSR_SITE_LIMIT:  cfg_in.site_limit = csr_wdata;
            crl_pkg::CSR_SITE_WINDOW: cfg_in.site_window = csr_wdata;
            crl_pkg::CSR_HOLD_TIME:   cfg_in.hold_time = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.page_limit <= 16'd2;
         cfg_ff.page_window <= 16'd1;
         cfg_ff.site_limit <= 16'd50;
         cfg_ff.site_window <= 16'd1;
         cfg_ff.hold_time <= 16'd10;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   crl_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_pop     (q_pop)
   );

   crl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .cfg       (cfg_ff),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/crl_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module crl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/crl_front.sv =====
// Front part: takes request transfers, hashes their table keys and queues them.
module crl_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  crl_pkg::req_type  req_data,
   output logic              q_valid,
   output crl_pkg::work_type q_data,
   input  logic              q_pop
);

   crl_pkg::work_type              slot_ff [crl_pkg::QUEUE_DEPTH];
   logic [crl_pkg::QPTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [crl_pkg::QPTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [crl_pkg::QPTR_BITS:0]    cnt_ff, cnt_in;
   crl_pkg::work_type              work;
   logic                           push;

   always_comb begin
      work.req = req_data;
      work.hold_idx = crl_pkg::slot_hash(crl_pkg::ETYPE_HOLD, req_data.client_addr, 32'd0);
      work.page_idx = crl_pkg::slot_hash(crl_pkg::ETYPE_PAGE, req_data.client_addr,
                                         req_data.page_id);
      work.site_idx = crl_pkg::slot_hash(crl_pkg::ETYPE_SITE, req_data.client_addr, 32'd0);
   end

   assign req_ready = (cnt_ff != (crl_pkg::QPTR_BITS+1)'(crl_pkg::QUEUE_DEPTH));
   assign push = req_valid && req_ready;
   assign q_valid = (cnt_ff != '0);
   assign q_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in = cnt_ff + (crl_pkg::QPTR_BITS+1)'(push) - (crl_pkg::QPTR_BITS+1)'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= work;
      end
   end

endmodule

// ===== rtl/crl_back.sv =====
// Back part: whitelist, probed entry table lookups, counter updates and result register.
module crl_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  crl_pkg::work_type q_data,
   output logic              q_pop,
   input  crl_pkg::cfg_type  cfg,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output crl_pkg::rsp_type  rsp_data
);

   localparam int EW = $bits(crl_pkg::tbl_entry_type);
   localparam logic [crl_pkg::IDX_BITS:0] FILL_FULL = (crl_pkg::IDX_BITS+1)'(crl_pkg::TABLE_ENTRIES);

   crl_pkg::back_state_type state_ff, state_in;
   crl_pkg::phase_type      phase_ff, phase_in;
   crl_pkg::work_type       work_ff, work_in;
   crl_pkg::tbl_entry_type  entry_ff, entry_in, rd_entry, wr_entry;
   logic [crl_pkg::IDX_BITS-1:0] ptr_ff, ptr_in, probes_ff, probes_in, clr_ff, clr_in;
   logic [crl_pkg::IDX_BITS-1:0] rd_idx, wr_idx;
   logic [crl_pkg::IDX_BITS:0]   fill_ff, fill_in;
   logic found_ff, found_in, from_site_ff, from_site_in;
   logic deny_ff, deny_in, held_ff, held_in, full_ff, full_in;
   logic [1:0] verdict_ff, verdict_in;
   logic rsp_valid_ff, rsp_valid_in;
   crl_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic allow_valid_ff [crl_pkg::ALLOW_ENTRIES];
   logic allow_valid_in [crl_pkg::ALLOW_ENTRIES];
   logic [31:0] allow_addr_ff [crl_pkg::ALLOW_ENTRIES];
   logic [31:0] allow_addr_in [crl_pkg::ALLOW_ENTRIES];
   logic [2:0]  allow_prefix_ff [crl_pkg::ALLOW_ENTRIES];
   logic [2:0]  allow_prefix_in [crl_pkg::ALLOW_ENTRIES];
   logic wr_en, lookup_start, probe_more, out_free, match, have_room;
   logic listed, dup, free_any;
   logic [crl_pkg::ALLOW_BITS-1:0] free_idx;
   logic [2:0]  add_p;
   logic [31:0] add_a, key_page, d, lim32, win32;
   logic [1:0]  key_type;
   logic [crl_pkg::COUNT_BITS-1:0] base_cnt;
   logic in_win, hit;

   logic [EW-1:0] rd_raw;

   crl_ram #(.WIDTH(EW), .DEPTH(crl_pkg::TABLE_ENTRIES)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_idx),
      .wr_data (wr_entry),
      .rd_addr (rd_idx),
      .rd_data (rd_raw)
   );

   assign rd_entry = rd_raw;
   assign rd_idx = ptr_ff;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign have_room = (fill_ff != FILL_FULL);
   assign q_pop = (state_ff == crl_pkg::BS_IDLE) && q_valid;

   // Whitelist match and add.
   always_comb begin
      listed = 1'b0;
      dup = 1'b0;
      free_any = 1'b0;
      free_idx = '0;
      add_p = (work_ff.req.prefix_octets inside {[3'd1:3'd3]}) ? work_ff.req.prefix_octets : 3'd4;
      add_a = work_ff.req.client_addr & crl_pkg::prefix_mask(add_p);
      for (int i = crl_pkg::ALLOW_ENTRIES - 1; i >= 0; i--) begin
         if (allow_valid_ff[i] && ((work_ff.req.client_addr &
             crl_pkg::prefix_mask(allow_prefix_ff[i])) == allow_addr_ff[i])) begin
            listed = 1'b1;
         end
         if (allow_valid_ff[i] && allow_prefix_ff[i] == add_p && allow_addr_ff[i] == add_a) begin
            dup = 1'b1;
         end
         if (!allow_valid_ff[i]) begin
            free_any = 1'b1;
            free_idx = crl_pkg::ALLOW_BITS'(i);
         end
      end
   end

   // Key of the current lookup and counter arithmetic.
   always_comb begin
      case (phase_ff)
         crl_pkg::PH_PAGE: begin
            key_type = crl_pkg::ETYPE_PAGE;
            key_page = work_ff.req.page_id;
            lim32 = 32'(cfg.page_limit);
            win32 = 32'(cfg.page_window);
         end
         crl_pkg::PH_SITE: begin
            key_type = crl_pkg::ETYPE_SITE;
            key_page = 32'd0;
            lim32 = 32'(cfg.site_limit);
            win32 = 32'(cfg.site_window);
         end
         default: begin
            key_type = crl_pkg::ETYPE_HOLD;
            key_page = 32'd0;
            lim32 = 32'(cfg.site_limit);
            win32 = 32'(cfg.hold_time);
         end
      endcase
      match = rd_entry.etype == key_type && rd_entry.addr == work_ff.req.client_addr &&
              rd_entry.page == key_page;
      d = work_ff.req.now_seconds - entry_ff.stamp;
      in_win = d < win32;
      hit = in_win && (32'(entry_ff.count) >= lim32);
      base_cnt = in_win ? entry_ff.count : '0;
   end

   // Next state.
   always_comb begin
      case (state_ff)
         crl_pkg::BS_CLEAR:    state_in = (clr_ff == '1) ? crl_pkg::BS_IDLE : crl_pkg::BS_CLEAR;
         crl_pkg::BS_IDLE:     state_in = q_valid ? crl_pkg::BS_CLASSIFY : crl_pkg::BS_IDLE;
         crl_pkg::BS_CLASSIFY: state_in = lookup_start ? crl_pkg::BS_READ : crl_pkg::BS_DONE;
         crl_pkg::BS_READ:     state_in = crl_pkg::BS_COMPARE;
         crl_pkg::BS_COMPARE:  state_in = probe_more ? crl_pkg::BS_READ : crl_pkg::BS_ACT;
         crl_pkg::BS_ACT:      state_in = lookup_start ? crl_pkg::BS_READ : crl_pkg::BS_DONE;
         crl_pkg::BS_DONE:     state_in = out_free ? crl_pkg::BS_IDLE : crl_pkg::BS_DONE;
         default:              state_in = crl_pkg::BS_CLEAR;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      phase_in = phase_ff;
      work_in = work_ff;
      entry_in = entry_ff;
      ptr_in = ptr_ff;
      probes_in = probes_ff;
      clr_in = clr_ff;
      fill_in = fill_ff;
      found_in = found_ff;
      from_site_in = from_site_ff;
      deny_in = deny_ff;
      held_in = held_ff;
      full_in = full_ff;
      verdict_in = verdict_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in = rsp_data_ff;
      allow_valid_in = allow_valid_ff;
      allow_addr_in = allow_addr_ff;
      allow_prefix_in = allow_prefix_ff;
      lookup_start = 1'b0;
      probe_more = 1'b0;
      wr_en = 1'b0;
      wr_idx = ptr_ff;
      wr_entry = entry_ff;
      case (state_ff)
         crl_pkg::BS_CLEAR: begin
            wr_en = 1'b1;
            wr_idx = clr_ff;
            wr_entry = '0;
            clr_in = clr_ff + 1'b1;
         end
         crl_pkg::BS_IDLE: begin
            if (q_valid) begin
               work_in = q_data;
               deny_in = 1'b0;
               held_in = 1'b0;
               full_in = 1'b0;
            end
         end
         crl_pkg::BS_CLASSIFY: begin
            verdict_in = crl_pkg::VERDICT_ALLOW;
            if (work_ff.req.kind == crl_pkg::KIND_ALLOW_ADD) begin
               if (!dup) begin
                  if (free_any) begin
                     allow_valid_in[free_idx] = 1'b1;
                     allow_addr_in[free_idx] = add_a;
                     allow_prefix_in[free_idx] = add_p;
                  end else begin
                     full_in = 1'b1;
                  end
               end
            end else if (listed || work_ff.req.excluded) begin
               verdict_in = crl_pkg::VERDICT_BYPASS;
            end else begin
               lookup_start = 1'b1;
               phase_in = crl_pkg::PH_HOLD;
               ptr_in = work_ff.hold_idx;
               probes_in = '0;
            end
         end
         crl_pkg::BS_COMPARE: begin
            entry_in = rd_entry;
            found_in = rd_entry.valid && match;
            if (rd_entry.valid && !match && probes_ff != '1) begin
               probe_more = 1'b1;
               ptr_in = ptr_ff + 1'b1;
               probes_in = probes_ff + 1'b1;
            end
         end
         crl_pkg::BS_ACT: begin
            case (phase_ff)
               crl_pkg::PH_HOLD: begin
                  if (found_ff && in_win) begin
                     deny_in = 1'b1;
                     wr_en = 1'b1;
                     wr_entry.stamp = work_ff.req.now_seconds;
                  end else begin
                     lookup_start = 1'b1;
                     phase_in = crl_pkg::PH_PAGE;
                     ptr_in = work_ff.page_idx;
                     probes_in = '0;
                  end
               end
               crl_pkg::PH_STORE: begin
                  wr_entry.valid = 1'b1;
                  wr_entry.etype = crl_pkg::ETYPE_HOLD;
                  wr_entry.addr = work_ff.req.client_addr;
                  wr_entry.page = 32'd0;
                  wr_entry.stamp = work_ff.req.now_seconds;
                  wr_entry.count = '0;
                  if (found_ff) begin
                     wr_en = 1'b1;
                     held_in = 1'b1;
                  end else if (have_room) begin
                     wr_en = 1'b1;
                     held_in = 1'b1;
                     fill_in = fill_ff + 1'b1;
                  end else begin
                     full_in = 1'b1;
                  end
                  if (!from_site_ff) begin
                     lookup_start = 1'b1;
                     phase_in = crl_pkg::PH_SITE;
                     ptr_in = work_ff.site_idx;
                     probes_in = '0;
                  end
               end
               default: begin
                  if (!found_ff) begin
                     wr_entry.valid = 1'b1;
                     wr_entry.etype = key_type;
                     wr_entry.addr = work_ff.req.client_addr;
                     wr_entry.page = key_page;
                     wr_entry.stamp = work_ff.req.now_seconds;
                     wr_entry.count = '0;
                     if (have_room) begin
                        wr_en = 1'b1;
                        fill_in = fill_ff + 1'b1;
                     end else begin
                        full_in = 1'b1;
                     end
                  end else begin
                     wr_en = 1'b1;
                     wr_entry.stamp = work_ff.req.now_seconds;
                     wr_entry.count = (base_cnt == crl_pkg::COUNT_MAX) ? base_cnt :
                                      base_cnt + 1'b1;
                  end
                  from_site_in = (phase_ff == crl_pkg::PH_SITE);
                  if (found_ff && hit) begin
                     deny_in = 1'b1;
                     lookup_start = 1'b1;
                     phase_in = crl_pkg::PH_STORE;
                     ptr_in = work_ff.hold_idx;
                     probes_in = '0;
                  end else if (phase_ff == crl_pkg::PH_PAGE) begin
                     lookup_start = 1'b1;
                     phase_in = crl_pkg::PH_SITE;
                     ptr_in = work_ff.site_idx;
                     probes_in = '0;
                  end
               end
            endcase
         end
         crl_pkg::BS_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.verdict = deny_ff ? crl_pkg::VERDICT_DENY : verdict_ff;
               rsp_data_in.hold_started = held_ff;
               rsp_data_in.table_full = full_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= crl_pkg::BS_CLEAR;
         clr_ff <= '0;
         fill_ff <= '0;
         deny_ff <= 1'b0;
         held_ff <= 1'b0;
         full_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < crl_pkg::ALLOW_ENTRIES; i++) begin
            allow_valid_ff[i] <= 1'b0;
         end
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         fill_ff <= fill_in;
         deny_ff <= deny_in;
         held_ff <= held_in;
         full_ff <= full_in;
         rsp_valid_ff <= rsp_valid_in;
         allow_valid_ff <= allow_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      phase_ff <= phase_in;
      work_ff <= work_in;
      entry_ff <= entry_in;
      ptr_ff <= ptr_in;
      probes_ff <= probes_in;
      found_ff <= found_in;
      from_site_ff <= from_site_in;
      verdict_ff <= verdict_in;
      rsp_data_ff <= rsp_data_in;
      allow_addr_ff <= allow_addr_in;
      allow_prefix_ff <= allow_prefix_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   assert property (@(posedge clock) disable iff (reset) fill_ff <= FILL_FULL)
      else $error("Entry fill count exceeds the table size.");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == crl_pkg::BS_COMPARE |-> $past(state_ff) == crl_pkg::BS_READ)
      else $error("Compare step without a preceding table read.");

   assert property (@(posedge clock) disable iff (reset) held_ff |-> deny_ff)
      else $error("Hold stored without a denial.");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == crl_pkg::BS_CLEAR |-> !rsp_valid_ff && !q_pop)
      else $error("Traffic during the table clearing pass.");

endmodule
